// File: hdl/load_store_multiple_sequencer_unit_macros.svh
// Assertion macros for the load/store multiple sequencer.
`ifndef LOAD_STORE_MULTIPLE_SEQUENCER_UNIT_MACROS_SVH
`define LOAD_STORE_MULTIPLE_SEQUENCER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LSMS_ASSERT_SAME(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error("lsms: same-cycle check failed");
`define LSMS_ASSERT_NEXT(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("lsms: next-cycle check failed");
`else
`define LSMS_ASSERT_SAME(label, clk, rst, cause, effect)
`define LSMS_ASSERT_NEXT(label, clk, rst, cause, effect)
`endif

`endif

// File: hdl/lsms_pkg.sv
package lsms_pkg;

   localparam int ADDR_WIDTH = 32;
   localparam int LIST_WIDTH = 16;
   localparam int REG_WIDTH  = 4;

   localparam logic [ADDR_WIDTH-1:0] WORD_STEP = 32'd4;
   localparam logic [REG_WIDTH-1:0]  REG_LAST  = 4'hF;

   localparam int LIST_LSB  = 0;
   localparam int BASE_LSB  = 16;
   localparam int LOAD_BIT  = 20;
   localparam int WBACK_BIT = 21;
   localparam int UP_BIT    = 23;
   localparam int PRE_BIT   = 24;

   typedef logic [1:0] step_type;

   localparam step_type STEP_IDLE  = 2'd0;
   localparam step_type STEP_SCAN  = 2'd1;
   localparam step_type STEP_CLOSE = 2'd2;

   typedef enum logic [1:0] {
      JUMP_NEVER,
      JUMP_START,
      JUMP_SCAN_END,
      JUMP_ALWAYS
   } jump_cond_type;

   typedef struct packed {
      logic          busy;
      logic          load;
      logic          scan;
      logic          close;
      jump_cond_type cond;
      step_type      target;
   } ucode_word_type;

   function automatic ucode_word_type ucode_rom(input step_type addr);
      ucode_word_type cw;
      cw = '{busy: 1'b0, load: 1'b0, scan: 1'b0, close: 1'b0,
             cond: JUMP_NEVER, target: STEP_IDLE};
      case (addr)
         STEP_IDLE: begin
            cw = '{busy: 1'b0, load: 1'b1, scan: 1'b0, close: 1'b0,
                   cond: JUMP_START, target: STEP_SCAN};
         end
         STEP_SCAN: begin
            cw = '{busy: 1'b1, load: 1'b0, scan: 1'b1, close: 1'b0,
                   cond: JUMP_SCAN_END, target: STEP_CLOSE};
         end
         STEP_CLOSE: begin
            cw = '{busy: 1'b1, load: 1'b0, scan: 1'b0, close: 1'b1,
                   cond: JUMP_ALWAYS, target: STEP_IDLE};
         end
         default: begin
            cw = '{busy: 1'b1, load: 1'b0, scan: 1'b0, close: 1'b0,
                   cond: JUMP_ALWAYS, target: STEP_IDLE};
         end
      endcase
      return cw;
   endfunction

endpackage

// File: hdl/load_store_multiple_sequencer_unit.sv
// Load/store multiple address sequencer. Raise start with an instruction word and
// the base register value; the request is taken when busy is low. The unit walks
// all sixteen register positions, one per cycle, and for each register set in the
// list pulses rsp_strobe for one cycle with its index and bus address; then one
// closing record (rsp_last) carries the updated base and the writeback flag. Busy
// stays high after acceptance through the 16 scan steps of the microprogram and
// the one close step; the load step that follows takes the next request, so a new
// request is taken only once the last one is through, whatever the list holds.
// Results are registered and show in the cycle after the step that makes them,
// so the closing record shows in the first cycle with busy low. Results cannot be
// held off: the receiver must take each one in the cycle it is strobed.
`include "load_store_multiple_sequencer_unit_macros.svh"

module load_store_multiple_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_base_value,
   output logic        rsp_strobe,
   output logic        rsp_transfer_valid,
   output logic [3:0]  rsp_reg_index,
   output logic [31:0] rsp_word_address,
   output logic        rsp_is_load,
   output logic [3:0]  rsp_base_reg,
   output logic        rsp_write_base,
   output logic [31:0] rsp_new_base,
   output logic        rsp_last
);

   lsms_pkg::ucode_word_type cw;
   lsms_pkg::step_type       upc_ff, upc_in;
   logic                     take_jump;

   logic [lsms_pkg::LIST_WIDTH-1:0] list_ff, list_in;
   logic [lsms_pkg::REG_WIDTH-1:0]  base_reg_ff, base_reg_in;
   logic [lsms_pkg::REG_WIDTH-1:0]  idx_ff, idx_in;
   logic [lsms_pkg::ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic                            ld_ff, ld_in;
   logic                            wb_ff, wb_in;
   logic                            up_ff, up_in;
   logic                            pre_ff, pre_in;

   logic [lsms_pkg::REG_WIDTH-1:0]  reg_sel;
   logic [lsms_pkg::ADDR_WIDTH-1:0] step_addr;
   logic                            hit;
   logic                            scan_end;

   logic                            strobe_ff, strobe_in;
   logic                            tv_ff, tv_in;
   logic [lsms_pkg::REG_WIDTH-1:0]  reg_index_ff, reg_index_in;
   logic [lsms_pkg::ADDR_WIDTH-1:0] word_address_ff, word_address_in;
   logic                            is_load_ff, is_load_in;
   logic [lsms_pkg::REG_WIDTH-1:0]  rn_ff, rn_in;
   logic                            write_base_ff, write_base_in;
   logic [lsms_pkg::ADDR_WIDTH-1:0] new_base_ff, new_base_in;
   logic                            last_ff, last_in;

   always_comb begin
      cw        = lsms_pkg::ucode_rom(upc_ff);
      reg_sel   = up_ff ? idx_ff : ~idx_ff;
      hit       = list_ff[reg_sel];
      step_addr = up_ff ? addr_ff + lsms_pkg::WORD_STEP : addr_ff - lsms_pkg::WORD_STEP;
      scan_end  = (idx_ff == lsms_pkg::REG_LAST);

      case (cw.cond)
         lsms_pkg::JUMP_START:    take_jump = start;
         lsms_pkg::JUMP_SCAN_END: take_jump = scan_end;
         lsms_pkg::JUMP_ALWAYS:   take_jump = 1'b1;
         default:                 take_jump = 1'b0;
      endcase
      upc_in = take_jump ? cw.target : upc_ff;

      list_in     = list_ff;
      base_reg_in = base_reg_ff;
      idx_in      = idx_ff;
      addr_in     = addr_ff;
      ld_in       = ld_ff;
      wb_in       = wb_ff;
      up_in       = up_ff;
      pre_in      = pre_ff;

      // load the request
      if (cw.load && start) begin
         list_in     = req_instr_word[lsms_pkg::LIST_LSB +: lsms_pkg::LIST_WIDTH];
         base_reg_in = req_instr_word[lsms_pkg::BASE_LSB +: lsms_pkg::REG_WIDTH];
         ld_in       = req_instr_word[lsms_pkg::LOAD_BIT];
         wb_in       = req_instr_word[lsms_pkg::WBACK_BIT];
         up_in       = req_instr_word[lsms_pkg::UP_BIT];
         pre_in      = req_instr_word[lsms_pkg::PRE_BIT];
         addr_in     = req_base_value;
         idx_in      = '0;
      end

      // advance the scan, step the address on each listed register
      if (cw.scan) begin
         idx_in = idx_ff + 1'b1;
         if (hit) begin
            addr_in = step_addr;
         end
      end

      strobe_in       = (cw.scan && hit) || cw.close;
      tv_in           = cw.scan;
      reg_index_in    = cw.scan ? reg_sel : '0;
      word_address_in = cw.scan ? (pre_ff ? step_addr : addr_ff) : '0;
      is_load_in      = ld_ff;
      rn_in           = base_reg_ff;
      write_base_in   = cw.close ? wb_ff : 1'b0;
      new_base_in     = cw.close ? addr_ff : '0;
      last_in         = cw.close;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff    <= lsms_pkg::STEP_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         upc_ff    <= upc_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ff         <= list_in;
      base_reg_ff     <= base_reg_in;
      idx_ff          <= idx_in;
      addr_ff         <= addr_in;
      ld_ff           <= ld_in;
      wb_ff           <= wb_in;
      up_ff           <= up_in;
      pre_ff          <= pre_in;
      tv_ff           <= tv_in;
      reg_index_ff    <= reg_index_in;
      word_address_ff <= word_address_in;
      is_load_ff      <= is_load_in;
      rn_ff           <= rn_in;
      write_base_ff   <= write_base_in;
      new_base_ff     <= new_base_in;
      last_ff         <= last_in;
   end

   assign busy               = cw.busy;
   assign rsp_strobe         = strobe_ff;
   assign rsp_transfer_valid = tv_ff;
   assign rsp_reg_index      = reg_index_ff;
   assign rsp_word_address   = word_address_ff;
   assign rsp_is_load        = is_load_ff;
   assign rsp_base_reg       = rn_ff;
   assign rsp_write_base     = write_base_ff;
   assign rsp_new_base       = new_base_ff;
   assign rsp_last           = last_ff;

   `LSMS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe)
   `LSMS_ASSERT_NEXT(a_close_last, clock, reset, upc_ff == lsms_pkg::STEP_CLOSE, rsp_strobe && rsp_last && !rsp_transfer_valid)
   `LSMS_ASSERT_SAME(a_xfer_busy, clock, reset, rsp_strobe && rsp_transfer_valid, busy)
   `LSMS_ASSERT_SAME(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy)

endmodule

// File: tb/load_store_multiple_sequencer_unit_test.sv
module load_store_multiple_sequencer_unit_test;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 320;
   localparam int TIMEOUT_TIME  = 2 * HALF_PERIOD * 200_000;
   localparam int PRINT_LIMIT   = 100;

   typedef enum logic [1:0] {
      MODE_DA = 2'd0,
      MODE_IA = 2'd1,
      MODE_DB = 2'd2,
      MODE_IB = 2'd3
   } addr_mode_type;

   typedef struct {
      logic                            transfer_valid;
      logic [lsms_pkg::REG_WIDTH-1:0]  reg_index;
      logic [lsms_pkg::ADDR_WIDTH-1:0] word_address;
      logic                            is_load;
      logic [lsms_pkg::REG_WIDTH-1:0]  base_reg;
      logic                            write_base;
      logic [lsms_pkg::ADDR_WIDTH-1:0] new_base;
      logic                            last;
   } xfer_record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_instr_word = '0;
   logic [31:0] req_base_value = '0;
   logic        rsp_strobe;
   logic        rsp_transfer_valid;
   logic [3:0]  rsp_reg_index;
   logic [31:0] rsp_word_address;
   logic        rsp_is_load;
   logic [3:0]  rsp_base_reg;
   logic        rsp_write_base;
   logic [31:0] rsp_new_base;
   logic        rsp_last;

   xfer_record_type pending_records[$];
   int              mismatch_count = 0;
   int              burst_left = 0;

   load_store_multiple_sequencer_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_instr_word     (req_instr_word),
      .req_base_value     (req_base_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_transfer_valid (rsp_transfer_valid),
      .rsp_reg_index      (rsp_reg_index),
      .rsp_word_address   (rsp_word_address),
      .rsp_is_load        (rsp_is_load),
      .rsp_base_reg       (rsp_base_reg),
      .rsp_write_base     (rsp_write_base),
      .rsp_new_base       (rsp_new_base),
      .rsp_last           (rsp_last)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("error: %s got %h want %h at %0t", what, got, want, $time);
      end
      mismatch_count++;
   endtask

   function automatic logic [31:0] make_word(
         input logic [lsms_pkg::LIST_WIDTH-1:0] list,
         input logic [lsms_pkg::REG_WIDTH-1:0]  rn,
         input logic ld, input logic wb,
         input addr_mode_type mode,
         input logic [31:0] noise);
      logic [31:0] word;
      word = noise;
      word[lsms_pkg::LIST_LSB +: lsms_pkg::LIST_WIDTH] = list;
      word[lsms_pkg::BASE_LSB +: lsms_pkg::REG_WIDTH]  = rn;
      word[lsms_pkg::LOAD_BIT]                         = ld;
      word[lsms_pkg::WBACK_BIT]                        = wb;
      word[lsms_pkg::UP_BIT +: 2]                      = mode;
      return word;
   endfunction

   // walk the list in mode order and queue one record per set bit, then the close
   function automatic void predict_transfers(input logic [31:0] word,
                                             input logic [31:0] base);
      logic [lsms_pkg::ADDR_WIDTH-1:0] addr;
      logic [lsms_pkg::REG_WIDTH-1:0]  idx;
      logic                            up;
      logic                            pre;
      xfer_record_type                 rec;
      addr = base;
      up   = word[lsms_pkg::UP_BIT];
      pre  = word[lsms_pkg::PRE_BIT];
      for (int n = 0; n < lsms_pkg::LIST_WIDTH; n++) begin
         idx = up ? lsms_pkg::REG_WIDTH'(n)
                  : lsms_pkg::REG_LAST - lsms_pkg::REG_WIDTH'(n);
         if (word[lsms_pkg::LIST_LSB + idx]) begin
            if (pre) begin
               addr = up ? addr + lsms_pkg::WORD_STEP : addr - lsms_pkg::WORD_STEP;
            end
            rec.transfer_valid = 1'b1;
            rec.reg_index      = idx;
            rec.word_address   = addr;
            rec.is_load        = word[lsms_pkg::LOAD_BIT];
            rec.base_reg       = word[lsms_pkg::BASE_LSB +: lsms_pkg::REG_WIDTH];
            rec.write_base     = 1'b0;
            rec.new_base       = '0;
            rec.last           = 1'b0;
            pending_records.push_back(rec);
            if (!pre) begin
               addr = up ? addr + lsms_pkg::WORD_STEP : addr - lsms_pkg::WORD_STEP;
            end
         end
      end
      rec.transfer_valid = 1'b0;
      rec.reg_index      = '0;
      rec.word_address   = '0;
      rec.is_load        = word[lsms_pkg::LOAD_BIT];
      rec.base_reg       = word[lsms_pkg::BASE_LSB +: lsms_pkg::REG_WIDTH];
      rec.write_base     = word[lsms_pkg::WBACK_BIT];
      rec.new_base       = addr;
      rec.last           = 1'b1;
      pending_records.push_back(rec);
   endfunction

   always @(posedge clock) begin : check_results
      xfer_record_type want;
      if (!reset) begin
         if (start === 1'b1 && busy === 1'b0) begin
            predict_transfers(req_instr_word, req_base_value);
         end
         if (rsp_strobe !== 1'b0) begin
            if (pending_records.size() == 0) begin
               report_mismatch("unexpected result, address", rsp_word_address, '0);
            end else begin
               want = pending_records.pop_front();
               if (rsp_transfer_valid !== want.transfer_valid)
                  report_mismatch("transfer_valid", 32'(rsp_transfer_valid),
                                  32'(want.transfer_valid));
               if (rsp_reg_index !== want.reg_index)
                  report_mismatch("reg_index", 32'(rsp_reg_index), 32'(want.reg_index));
               if (rsp_word_address !== want.word_address)
                  report_mismatch("word_address", rsp_word_address, want.word_address);
               if (rsp_is_load !== want.is_load)
                  report_mismatch("is_load", 32'(rsp_is_load), 32'(want.is_load));
               if (rsp_base_reg !== want.base_reg)
                  report_mismatch("base_reg", 32'(rsp_base_reg), 32'(want.base_reg));
               if (rsp_write_base !== want.write_base)
                  report_mismatch("write_base", 32'(rsp_write_base),
                                  32'(want.write_base));
               if (rsp_new_base !== want.new_base)
                  report_mismatch("new_base", rsp_new_base, want.new_base);
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
         end
      end
   end

   task automatic send_request(input logic [31:0] word, input logic [31:0] base);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      start          <= 1'b1;
      req_instr_word <= word;
      req_base_value <= base;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // hold off new requests until every queued result has arrived or the wait limit runs out
   task automatic drain_results();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while (pending_records.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_records.size() != 0) begin
         report_mismatch("results never arrived, count", pending_records.size(), 0);
         pending_records.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic test_each_mode();
      for (int m = 0; m < 4; m++) begin
         send_request(make_word(16'hFFFF, 4'd13, 1'b1, 1'b1, addr_mode_type'(m), '0),
                      32'h0000_1000);
         send_request(make_word(16'h8001, 4'd2, 1'b0, 1'b0, addr_mode_type'(m), '0),
                      32'h8000_0000);
      end
   endtask

   task automatic test_field_extremes();
      send_request(make_word(16'h0000, 4'd7, 1'b1, 1'b1, MODE_IA, '0), 32'hDEAD_BEEF);
      send_request(make_word(16'h0001, 4'd0, 1'b0, 1'b1, MODE_IB, '0), 32'hFFFF_FFFC);
      send_request(make_word(16'h8000, 4'd15, 1'b1, 1'b1, MODE_DB, '0), 32'h0000_0000);
      send_request(make_word(16'hFFFF, 4'd1, 1'b0, 1'b1, MODE_DA, '0), 32'h0000_0008);
      send_request(make_word(16'hFFFF, 4'd14, 1'b1, 1'b1, MODE_IA, '0), 32'hFFFF_FFF0);
      send_request(make_word(16'h0060, 4'd5, 1'b1, 1'b1, MODE_IB, '0), 32'h0000_4000);
      send_request(make_word(16'h0000, 4'd3, 1'b0, 1'b0, MODE_DA, '1), 32'h1234_5678);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_pause_until_idle();
      send_request(make_word(16'hA5A5, 4'd9, 1'b1, 1'b0, MODE_DB, '0), 32'h0001_0000);
      send_request(make_word(16'h5A5A, 4'd9, 1'b0, 1'b1, MODE_IA, '0), 32'h0001_0000);
      drain_results();
      send_request(make_word(16'h0F0F, 4'd4, 1'b1, 1'b1, MODE_IB, '0), 32'h7FFF_FFFC);
   endtask

   task automatic test_random_requests();
      logic [lsms_pkg::LIST_WIDTH-1:0] list;
      logic [31:0]                     base;
      logic [31:0]                     word;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 7))
            0: begin
               list = '0;
            end
            1: begin
               list = lsms_pkg::LIST_WIDTH'(1)
                      << $urandom_range(0, lsms_pkg::LIST_WIDTH - 1);
            end
            2: begin
               list = '1;
            end
            3: begin
               list = lsms_pkg::LIST_WIDTH'($urandom & $urandom);
            end
            4: begin
               list = lsms_pkg::LIST_WIDTH'($urandom | $urandom);
            end
            default: begin
               list = lsms_pkg::LIST_WIDTH'($urandom);
            end
         endcase
         case ($urandom_range(0, 3))
            0: begin
               base = $urandom_range(0, 64);
            end
            1: begin
               base = 32'hFFFF_FFFF - $urandom_range(0, 64);
            end
            default: begin
               base = $urandom;
            end
         endcase
         word = make_word(list, lsms_pkg::REG_WIDTH'($urandom), 1'($urandom),
                          1'($urandom), addr_mode_type'($urandom_range(0, 3)),
                          $urandom);
         send_request(word, base);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_each_mode();
      test_field_extremes();
      test_pause_until_idle();
      test_random_requests();
      drain_results();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_TIME;
      $display("Mismatches found");
      $finish;
   end

endmodule
